// File: hdl/lclt_pkg.sv
// Shared types, register codes and helpers for the LED current load tracker.
// No dependencies; imported by lclt_alu and led_current_load_tracker_unit.
package lclt_pkg;

    // Operand and product widths of the shared arithmetic unit
    localparam int ALU_W  = 26;
    localparam int ALU_RW = ALU_W + 1;

    // Field widths fixed by the register map
    localparam int CNT_W   = 9;
    localparam int MA8_W   = 8;
    localparam int MA_W    = 18;
    localparam int CSUM_W  = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [MA_W-1:0]  MA_MAX     = {MA_W{1'b1}};
    localparam logic [MA8_W-1:0] FULL_LEVEL = 8'd255;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEDS_IN_USE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_MA     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_MA     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_MA   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PEAK_STEP   = 3'd4;

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } t_alu_op;

    // One request to the shared unit
    typedef struct packed {
        t_alu_op          op;
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
    } t_alu_req;

    // Clamp a 20-bit value to the 18-bit milliamp range
    function automatic logic [MA_W-1:0] sat_ma(input logic [19:0] v);
        logic [MA_W-1:0] res;
        res = (v > 20'(MA_MAX)) ? MA_MAX : v[MA_W-1:0];
        return res;
    endfunction

endpackage

// File: hdl/led_current_load_tracker_unit.sv
// Top level of the LED current load tracker: sequencer, per-LED store, state.
// Depends on lclt_pkg and lclt_alu.
//
// Usage:
//   Command channel: drive start high with led_index and the three colour
//   levels while busy is low; the word is taken at that edge and busy rises.
//   Each command gives exactly one result word, shown for one cycle with
//   o_result_valid high: ignored flag, load estimate, peak, new-peak event
//   and budget-crossing event. The receiver cannot stall; the word must be
//   captured in its strobe cycle.
//   Configuration: write words on the cfg channel (o_cfg_ready is always
//   high); index selects leds_in_use, idle mA, full-channel mA, budget or
//   peak step. Write only while busy is low and no result is pending.
//   Timing: busy stays high while a command is processed and the result
//   strobe follows in the next cycle, where a new command may already be
//   taken. Totals, products and correction steps run through one registered
//   add/subtract/multiply unit; the divide by 255 takes a reciprocal-series
//   estimate plus zero to three correction steps through that unit.
//   Reset: synchronous, active low. Control and state registers return to their
//   defaults; the per-LED store reads as zero at once through its valid bits.
module led_current_load_tracker_unit
    import lclt_pkg::*;
#(
    parameter int MAX_LEDS = 256
)(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [7:0]           i_led_index,
    input  logic [7:0]           i_red,
    input  logic [7:0]           i_green,
    input  logic [7:0]           i_blue,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MA_W-1:0]      i_cfg_data,
    output logic                 o_result_valid,
    output logic                 o_ignored,
    output logic [MA_W-1:0]      o_load_ma,
    output logic [MA_W-1:0]      o_peak_ma,
    output logic                 o_new_peak,
    output logic                 o_budget_crossed
);

    // Store depth: an 8-bit index never reaches beyond 256 entries
    localparam int SD      = (MAX_LEDS < 256) ? MAX_LEDS : 256;
    localparam int AW      = (SD > 1) ? $clog2(SD) : 1;
    localparam int CNT_CAP = (MAX_LEDS > 511) ? 511 : MAX_LEDS;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_RD   = 4'd1;
    localparam logic [3:0] ST_ACC  = 4'd2;
    localparam logic [3:0] ST_TOT  = 4'd3;
    localparam logic [3:0] ST_CHIP = 4'd4;
    localparam logic [3:0] ST_PROD = 4'd5;
    localparam logic [3:0] ST_FIX  = 4'd6;
    localparam logic [3:0] ST_FIXW = 4'd7;
    localparam logic [3:0] ST_SUMW = 4'd8;
    localparam logic [3:0] ST_OUT  = 4'd9;

    // Configuration registers
    logic [CNT_W-1:0] r_leds;
    logic [MA8_W-1:0] r_idle;
    logic [MA8_W-1:0] r_full;
    logic [MA_W-1:0]  r_budget;
    logic [MA_W-1:0]  r_step;

    // Tracker state
    logic [3:0]        r_state;
    logic [3:0]        n_state;
    logic [MA_W-1:0]   r_total;
    logic [MA_W-1:0]   r_peak;
    logic [MA_W-1:0]   r_rep;
    logic              r_over;
    logic [SD-1:0]     r_vld;
    logic [CSUM_W-1:0] mem [SD];

    // Per-item working registers
    logic [AW-1:0]     r_idx;
    logic [CSUM_W-1:0] r_sum;
    logic              r_ign;
    logic [CSUM_W-1:0] r_old_raw;
    logic              r_old_vld;
    logic [16:0]       r_chips;
    logic [18:0]       r_q;
    logic [10:0]       r_rem;
    logic [MA_W-1:0]   r_load;

    // Output registers
    logic              r_res_vld;
    logic              r_o_ign;
    logic [MA_W-1:0]   r_o_load;
    logic [MA_W-1:0]   r_o_peak;
    logic              r_o_np;
    logic              r_o_bc;

    t_alu_req          w_req;
    logic [ALU_RW-1:0] w_y;
    logic [CNT_W-1:0]  w_active;
    logic              w_accept;
    logic [CSUM_W-1:0] w_in_sum;
    logic [CSUM_W-1:0] w_old;
    logic [MA_W-1:0]   w_tot_new;
    logic [MA_W-1:0]   w_load_new;
    logic [18:0]       w_q_est;
    logic [ALU_RW-1:0] w_rem_full;
    logic              w_new_peak;
    logic              w_over;

    lclt_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_y   (w_y)
    );

    assign w_active = (r_leds > CNT_W'(CNT_CAP)) ? CNT_W'(CNT_CAP) : r_leds;
    assign w_accept = start && (r_state == ST_IDLE);
    assign w_in_sum = CSUM_W'(i_red) + CSUM_W'(i_green) + CSUM_W'(i_blue);
    assign w_old    = r_old_vld ? r_old_raw : '0;

    // Reciprocal series for floor(p / 255); the remainder stays below 1020
    assign w_q_est    = 19'(w_y[ALU_W-1:8]) + 19'(w_y[ALU_W-1:16])
                      + 19'(w_y[ALU_W-1:24]);
    assign w_rem_full = {1'b0, w_y[ALU_W-1:0]} - {w_q_est, 8'd0} + ALU_RW'(w_q_est);

    assign w_tot_new  = sat_ma(w_y[19:0]);
    assign w_load_new = sat_ma(w_y[19:0]);

    assign w_new_peak = {1'b0, r_peak} >= ({1'b0, r_rep} + {1'b0, r_step});
    assign w_over     = r_load > r_budget;

    // Sequence the shared unit
    always_comb begin
        n_state  = r_state;
        w_req.op = ALU_NOP;
        w_req.a  = '0;
        w_req.b  = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_RD;
                end
            end
            ST_RD: begin
                w_req.op = ALU_SUB;
                w_req.a  = ALU_W'(r_total);
                w_req.b  = ALU_W'(w_old);
                n_state  = ST_ACC;
            end
            ST_ACC: begin
                // After saturation the old entry can exceed the total: restart from zero
                w_req.op = ALU_ADD;
                w_req.a  = w_y[ALU_RW-1] ? '0 : ALU_W'(w_y[MA_W-1:0]);
                w_req.b  = ALU_W'(r_sum);
                n_state  = ST_TOT;
            end
            ST_TOT: begin
                w_req.op = ALU_MUL;
                w_req.a  = ALU_W'(w_active);
                w_req.b  = ALU_W'(r_idle);
                n_state  = ST_CHIP;
            end
            ST_CHIP: begin
                w_req.op = ALU_MUL;
                w_req.a  = ALU_W'(r_total);
                w_req.b  = ALU_W'(r_full);
                n_state  = ST_PROD;
            end
            ST_PROD: begin
                n_state = ST_FIX;
            end
            ST_FIX: begin
                w_req.op = ALU_SUB;
                w_req.a  = ALU_W'(r_rem);
                w_req.b  = ALU_W'(FULL_LEVEL);
                n_state  = ST_FIXW;
            end
            ST_FIXW: begin
                if (!w_y[ALU_RW-1]) begin
                    n_state = ST_FIX;
                end else begin
                    w_req.op = ALU_ADD;
                    w_req.a  = ALU_W'(r_chips);
                    w_req.b  = ALU_W'(r_q);
                    n_state  = ST_SUMW;
                end
            end
            ST_SUMW: begin
                n_state = ST_OUT;
            end
            ST_OUT: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state, configuration and tracker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_leds    <= 9'd256;
            r_idle    <= 8'd1;
            r_full    <= 8'd20;
            r_budget  <= 18'd2000;
            r_step    <= 18'd100;
            r_total   <= '0;
            r_peak    <= '0;
            r_rep     <= '0;
            r_over    <= 1'b0;
            r_vld     <= '0;
            r_res_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_res_vld <= (r_state == ST_OUT);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_LEDS_IN_USE: r_leds   <= i_cfg_data[CNT_W-1:0];
                    CFG_IDLE_MA:     r_idle   <= i_cfg_data[MA8_W-1:0];
                    CFG_FULL_MA:     r_full   <= i_cfg_data[MA8_W-1:0];
                    CFG_BUDGET_MA:   r_budget <= i_cfg_data;
                    CFG_PEAK_STEP:   r_step   <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == ST_TOT && !r_ign) begin
                r_total      <= w_tot_new;
                r_vld[r_idx] <= 1'b1;
            end
            if (r_state == ST_SUMW && !r_ign && w_load_new > r_peak) begin
                r_peak <= w_load_new;
            end
            if (r_state == ST_OUT) begin
                r_over <= w_over;
                if (w_new_peak) begin
                    r_rep <= r_peak;
                end
            end
        end
    end

    // Per-LED store: read on accept, write back once the total is known
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_old_raw <= mem[i_led_index[AW-1:0]];
            r_old_vld <= r_vld[i_led_index[AW-1:0]];
        end
        if (r_state == ST_TOT && !r_ign) begin
            mem[r_idx] <= r_sum;
        end
    end

    // Working registers and the result word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_idx <= i_led_index[AW-1:0];
            r_sum <= w_in_sum;
            r_ign <= {1'b0, i_led_index} >= w_active;
        end
        if (r_state == ST_CHIP) begin
            r_chips <= w_y[16:0];
        end
        if (r_state == ST_PROD) begin
            r_q   <= w_q_est;
            r_rem <= w_rem_full[10:0];
        end
        if (r_state == ST_FIXW && !w_y[ALU_RW-1]) begin
            r_q   <= r_q + 19'd1;
            r_rem <= w_y[10:0];
        end
        if (r_state == ST_SUMW) begin
            r_load <= w_load_new;
        end
        if (r_state == ST_OUT) begin
            r_o_ign  <= r_ign;
            r_o_load <= r_load;
            r_o_peak <= r_peak;
            r_o_np   <= w_new_peak;
            r_o_bc   <= w_over && !r_over;
        end
    end

    assign busy             = (r_state != ST_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_result_valid   = r_res_vld;
    assign o_ignored        = r_o_ign;
    assign o_load_ma        = r_o_load;
    assign o_peak_ma        = r_o_peak;
    assign o_new_peak       = r_o_np;
    assign o_budget_crossed = r_o_bc;

endmodule

// File: hdl/lclt_alu.sv
// Shared arithmetic unit: add, subtract with borrow, 18x8 multiply.
// Result is registered; depends on lclt_pkg.
module lclt_alu
    import lclt_pkg::*;
(
    input  logic              i_clk,
    input  t_alu_req          i_req,
    output logic [ALU_RW-1:0] o_y
);

    logic [ALU_RW-1:0] n_y;
    logic [ALU_RW-1:0] r_y;

    // Select the operation; subtract leaves the borrow in the top bit
    always_comb begin
        unique case (i_req.op)
            ALU_ADD: n_y = {1'b0, i_req.a} + {1'b0, i_req.b};
            ALU_SUB: n_y = {1'b0, i_req.a} - {1'b0, i_req.b};
            ALU_MUL: n_y = ALU_RW'(i_req.a[MA_W-1:0]) * ALU_RW'(i_req.b[MA8_W-1:0]);
            default: n_y = '0;
        endcase
    end

    // Register the result
    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule
